>>> hw/rtl/pose_change_detector_core_assert.svh
// Assertion macros shared by the pose change detector RTL.
`ifndef POSE_CHANGE_DETECTOR_CORE_ASSERT_SVH
`define POSE_CHANGE_DETECTOR_CORE_ASSERT_SVH

// Condition and consequence checked at the same clock edge.
`define PCD_ASSERT_SAME(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("pose change detector assertion failed");

// Consequence checked at the clock edge after the condition.
`define PCD_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("pose change detector assertion failed");

`endif

>>> hw/rtl/pcd_pkg.sv
// Package of the pose change detector: widths, codes, types and the step program.
package pcd_pkg;

    // Field widths.
    localparam int POS_BITS       = 21;
    localparam int QUAT_BITS      = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int DIST_W         = 16;
    localparam int COS_W          = 15;
    localparam int LIMIT_W        = 4;
    localparam int RUN_W          = 5;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    // Internal widths derived from the field widths.
    localparam int AXIS_RAW  = 34 - QUAT_FRAC_BITS;
    localparam int AXIS_W    = (AXIS_RAW > 31) ? 31 : AXIS_RAW;
    localparam int N_W       = 2 * AXIS_W;
    localparam int D_W       = N_W + 1;
    localparam int COS_SHIFT = 30;
    localparam int CMP_W     = 2 * N_W + COS_SHIFT;
    localparam int ACC_W     = CMP_W + 1;
    localparam int A_W       = CMP_W + 1;
    localparam int DIFF_W    = POS_BITS + 1;
    localparam int B_W       = (D_W > DIFF_W) ? D_W : DIFF_W;
    localparam int DIG_W     = 4;
    localparam int NDIG      = (B_W + DIG_W - 1) / DIG_W;
    localparam int BD_W      = NDIG * DIG_W;
    localparam int CNT_W     = $clog2(NDIG + 1);
    localparam int SUM_W     = 2 * POS_BITS + 2;
    localparam int THR2_W    = 2 * DIST_W;
    localparam int CC_W      = 2 * COS_W;
    localparam int DCMP_W    = (SUM_W > THR2_W) ? SUM_W : THR2_W;

    // Reset values of the configuration registers.
    localparam logic [DIST_W-1:0]  DIST_RESET  = DIST_W'(100);
    localparam logic [COS_W-1:0]   COS_RESET   = COS_W'(32270);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

    // Axis components are clamped to this magnitude.
    localparam logic signed [ACC_W-1:0] AXIS_MAX = ACC_W'(64'sd1073741823);
    localparam logic signed [ACC_W-1:0] AXIS_MIN = -AXIS_MAX;

    // Step program.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] CAPTURE_LAST = STEP_W'(7);
    localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(24);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST  = 2'd0,
        CFG_COS   = 2'd1,
        CFG_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_QW, OP_QX, OP_QY, OP_QZ,
        OP_DX, OP_DY, OP_DZ,
        OP_THR, OP_COS,
        OP_AX0, OP_AX1, OP_AX2,
        OP_RX0, OP_RX1, OP_RX2,
        OP_DOT, OP_N1, OP_N2, OP_CC, OP_CCN1
    } opnd_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_AX0, DST_AX1, DST_AX2, DST_SUM, DST_THR2, DST_DOT,
        DST_N1, DST_N2, DST_LHS, DST_CC, DST_CCN1, DST_RHS
    } dst_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH
    } seq_state_t;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
        logic  sub;
        logic  first;
        dst_t  dst;
    } step_t;

    typedef struct packed {
        logic                       func;
        logic signed [POS_BITS-1:0]  pos_x;
        logic signed [POS_BITS-1:0]  pos_y;
        logic signed [POS_BITS-1:0]  pos_z;
        logic signed [QUAT_BITS-1:0] quat_w;
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
    } item_t;

    typedef struct packed {
        logic             moving;
        logic             distance_over;
        logic             angle_over;
        logic [RUN_W-1:0] run_count;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0]  dist_mm;
        logic [COS_W-1:0]   cos;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic neg;
    } mul_stat_t;

    // One product per step; a step either opens a sum or adds to it, and the
    // last term of a sum names where the total goes.
    function automatic step_t step_info(input logic [STEP_W-1:0] s);
        step_t r;
        begin
            r = '{OP_QW, OP_QW, 1'b0, 1'b1, DST_NONE};
            unique case (s)
                // Rotated x-axis of the current quaternion.
                5'd0:  r = '{OP_QW, OP_QW, 1'b0, 1'b1, DST_NONE};
                5'd1:  r = '{OP_QX, OP_QX, 1'b0, 1'b0, DST_NONE};
                5'd2:  r = '{OP_QY, OP_QY, 1'b1, 1'b0, DST_NONE};
                5'd3:  r = '{OP_QZ, OP_QZ, 1'b1, 1'b0, DST_AX0};
                5'd4:  r = '{OP_QX, OP_QY, 1'b0, 1'b1, DST_NONE};
                5'd5:  r = '{OP_QW, OP_QZ, 1'b0, 1'b0, DST_AX1};
                5'd6:  r = '{OP_QX, OP_QZ, 1'b0, 1'b1, DST_NONE};
                5'd7:  r = '{OP_QW, OP_QY, 1'b1, 1'b0, DST_AX2};
                // Squared distance and squared threshold.
                5'd8:  r = '{OP_DX, OP_DX, 1'b0, 1'b1, DST_NONE};
                5'd9:  r = '{OP_DY, OP_DY, 1'b0, 1'b0, DST_NONE};
                5'd10: r = '{OP_DZ, OP_DZ, 1'b0, 1'b0, DST_SUM};
                5'd11: r = '{OP_THR, OP_THR, 1'b0, 1'b1, DST_THR2};
                // Dot product and squared axis lengths.
                5'd12: r = '{OP_RX0, OP_AX0, 1'b0, 1'b1, DST_NONE};
                5'd13: r = '{OP_RX1, OP_AX1, 1'b0, 1'b0, DST_NONE};
                5'd14: r = '{OP_RX2, OP_AX2, 1'b0, 1'b0, DST_DOT};
                5'd15: r = '{OP_RX0, OP_RX0, 1'b0, 1'b1, DST_NONE};
                5'd16: r = '{OP_RX1, OP_RX1, 1'b0, 1'b0, DST_NONE};
                5'd17: r = '{OP_RX2, OP_RX2, 1'b0, 1'b0, DST_N1};
                5'd18: r = '{OP_AX0, OP_AX0, 1'b0, 1'b1, DST_NONE};
                5'd19: r = '{OP_AX1, OP_AX1, 1'b0, 1'b0, DST_NONE};
                5'd20: r = '{OP_AX2, OP_AX2, 1'b0, 1'b0, DST_N2};
                // Both sides of the cosine test.
                5'd21: r = '{OP_DOT, OP_DOT, 1'b0, 1'b1, DST_LHS};
                5'd22: r = '{OP_COS, OP_COS, 1'b0, 1'b1, DST_CC};
                5'd23: r = '{OP_CC, OP_N1, 1'b0, 1'b1, DST_CCN1};
                5'd24: r = '{OP_CCN1, OP_N2, 1'b0, 1'b1, DST_RHS};
                default: r = '{OP_QW, OP_QW, 1'b0, 1'b1, DST_NONE};
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/pcd_mul.sv
// Shared digit-serial multiplier: signed operands, magnitude product and sign.
`include "pose_change_detector_core_assert.svh"

module pcd_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [pcd_pkg::A_W-1:0]  a,
    input  logic signed [pcd_pkg::B_W-1:0]  b,
    output pcd_pkg::mul_stat_t              stat,
    output logic [pcd_pkg::CMP_W-1:0]       prod
);
    import pcd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [A_W-1:0]       mag_a_reg, mag_a_next;
    logic [BD_W-1:0]      mag_b_reg, mag_b_next;
    logic [CMP_W-1:0]     prod_reg, prod_next;

    logic [A_W-1:0]       mag_a_in;
    logic [B_W-1:0]       mag_b_abs;
    logic [DIG_W-1:0]     digit;
    logic [A_W+DIG_W-1:0] partial;

    // Operand magnitudes.
    assign mag_a_in  = a[A_W-1] ? (A_W'(~a) + A_W'(1)) : A_W'(a);
    assign mag_b_abs = b[B_W-1] ? (B_W'(~b) + B_W'(1)) : B_W'(b);

    // One digit of the multiplier, most significant first.
    assign digit   = mag_b_reg[BD_W-1 -: DIG_W];
    assign partial = mag_a_reg * digit;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            neg_next   = a[A_W-1] ^ b[B_W-1];
            cnt_next   = CNT_W'(NDIG);
            mag_a_next = mag_a_in;
            mag_b_next = BD_W'(mag_b_abs);
            prod_next  = '0;
        end
        else if (busy_reg)
        begin
            prod_next  = (prod_reg << DIG_W) + CMP_W'(partial);
            mag_b_next = mag_b_reg << DIG_W;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        prod_reg  <= prod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.neg  = neg_reg;
    assign prod      = prod_reg;

    // A product is only started while the unit is free, and it ends cleanly.
    `PCD_ASSERT_SAME(a_mul_start_idle, clk, rst_n, start, !busy_reg)
    `PCD_ASSERT_SAME(a_mul_done_free, clk, rst_n, done_reg, !busy_reg)

endmodule

>>> hw/rtl/pcd_seq.sv
// Sequencer and operand registers that run the step program on the shared multiplier.
`include "pose_change_detector_core_assert.svh"

module pcd_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pcd_pkg::item_t   item,
    output logic             ready,
    input  pcd_pkg::cfg_t    cfg,
    input  logic             res_ready,
    output logic             res_valid,
    output pcd_pkg::result_t result
);
    import pcd_pkg::*;

    seq_state_t                 state_reg, state_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    item_t                      item_reg, item_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [AXIS_W-1:0]   ax_reg [3];
    logic signed [AXIS_W-1:0]   ax_next [3];
    logic signed [AXIS_W-1:0]   rax_reg [3];
    logic signed [AXIS_W-1:0]   rax_next [3];
    logic signed [POS_BITS-1:0] rpos_reg [3];
    logic signed [POS_BITS-1:0] rpos_next [3];
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [THR2_W-1:0]          thr2_reg, thr2_next;
    logic signed [D_W-1:0]      dot_reg, dot_next;
    logic [N_W-1:0]             n1_reg, n1_next;
    logic [N_W-1:0]             n2_reg, n2_next;
    logic [CMP_W-1:0]           lhs_reg, lhs_next;
    logic [CC_W-1:0]            cc_reg, cc_next;
    logic [CMP_W-1:0]           ccn1_reg, ccn1_next;
    logic [CMP_W-1:0]           rhs_reg, rhs_next;
    logic [RUN_W-1:0]           run_reg, run_next;

    step_t                      st;
    logic                       mul_start;
    mul_stat_t                  mul_stat;
    logic [CMP_W-1:0]           mul_prod;
    logic signed [A_W-1:0]      opnd_a;
    logic signed [B_W-1:0]      opnd_b;
    logic signed [DIFF_W-1:0]   dx, dy, dz;
    logic signed [ACC_W-1:0]    prod_ext, term, acc_sum, ax_raw, ax_clamp;
    logic                       dist_over, angle_over, moving;
    logic [RUN_W:0]             run_new, run_lim;

    // Position change against the reference.
    assign dx = DIFF_W'(item_reg.pos_x) - DIFF_W'(rpos_reg[0]);
    assign dy = DIFF_W'(item_reg.pos_y) - DIFF_W'(rpos_reg[1]);
    assign dz = DIFF_W'(item_reg.pos_z) - DIFF_W'(rpos_reg[2]);

    assign st = step_info(step_reg);

    // Operand selection for the multiplier.
    function automatic logic signed [A_W-1:0] opnd_value(input opnd_t sel);
        logic signed [A_W-1:0] v;
        begin
            v = '0;
            case (sel)
                OP_QW:   v = A_W'(item_reg.quat_w);
                OP_QX:   v = A_W'(item_reg.quat_x);
                OP_QY:   v = A_W'(item_reg.quat_y);
                OP_QZ:   v = A_W'(item_reg.quat_z);
                OP_DX:   v = A_W'(dx);
                OP_DY:   v = A_W'(dy);
                OP_DZ:   v = A_W'(dz);
                OP_THR:  v = A_W'(cfg.dist_mm);
                OP_COS:  v = A_W'(cfg.cos);
                OP_AX0:  v = A_W'(ax_reg[0]);
                OP_AX1:  v = A_W'(ax_reg[1]);
                OP_AX2:  v = A_W'(ax_reg[2]);
                OP_RX0:  v = A_W'(rax_reg[0]);
                OP_RX1:  v = A_W'(rax_reg[1]);
                OP_RX2:  v = A_W'(rax_reg[2]);
                OP_DOT:  v = A_W'(dot_reg);
                OP_N1:   v = A_W'(n1_reg);
                OP_N2:   v = A_W'(n2_reg);
                OP_CC:   v = A_W'(cc_reg);
                OP_CCN1: v = A_W'(ccn1_reg);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Both operands follow every register that the selection reads.
    always_comb
    begin
        opnd_a = opnd_value(st.a);
        opnd_b = B_W'(opnd_value(st.b));
    end

    pcd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opnd_a),
        .b     (opnd_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    // Signed accumulation of the finished product.
    assign prod_ext = {1'b0, mul_prod};
    assign term     = (mul_stat.neg ^ st.sub) ? (ACC_W'(~prod_ext) + ACC_W'(1)) : prod_ext;
    assign acc_sum  = (st.first ? ACC_W'(0) : acc_reg) + term;

    // Axis component: doubled for the cross terms, floor shift, then clamp.
    always_comb
    begin
        if (st.dst == DST_AX0)
        begin
            ax_raw = acc_sum >>> QUAT_FRAC_BITS;
        end
        else
        begin
            ax_raw = (acc_sum <<< 1) >>> QUAT_FRAC_BITS;
        end
        if (ax_raw > AXIS_MAX)
        begin
            ax_clamp = AXIS_MAX;
        end
        else if (ax_raw < AXIS_MIN)
        begin
            ax_clamp = AXIS_MIN;
        end
        else
        begin
            ax_clamp = ax_raw;
        end
    end

    // Flag evaluation and run counter update for a check.
    always_comb
    begin
        dist_over  = DCMP_W'(sum_reg) > DCMP_W'(thr2_reg);
        angle_over = (n1_reg != '0) && (n2_reg != '0) &&
                     ((dot_reg < 0) || (lhs_reg < rhs_reg));
        run_lim    = (RUN_W + 1)'(cfg.limit) + (RUN_W + 1)'(1);
        run_new    = (dist_over || angle_over) ?
                     ((RUN_W + 1)'(run_reg) + (RUN_W + 1)'(1)) : '0;
        moving     = 1'b0;
        if (run_new > (RUN_W + 1)'(cfg.limit))
        begin
            run_new = run_lim;
            moving  = 1'b1;
        end
    end

    // Sequencer: next state, writebacks and result.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        item_next  = item_reg;
        acc_next   = acc_reg;
        ax_next    = ax_reg;
        rax_next   = rax_reg;
        rpos_next  = rpos_reg;
        sum_next   = sum_reg;
        thr2_next  = thr2_reg;
        dot_next   = dot_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        lhs_next   = lhs_reg;
        cc_next    = cc_reg;
        ccn1_next  = ccn1_reg;
        rhs_next   = rhs_reg;
        run_next   = run_reg;
        mul_start  = 1'b0;
        ready      = 1'b0;
        res_valid  = 1'b0;
        if (item_reg.func)
        begin
            result = '{1'b0, 1'b0, 1'b0, run_reg};
        end
        else
        begin
            result = '{moving, dist_over, angle_over, RUN_W'(run_new)};
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    item_next  = item;
                    step_next  = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_stat.done)
                begin
                    acc_next = acc_sum;
                    case (st.dst)
                        DST_AX0:  ax_next[0] = AXIS_W'(ax_clamp);
                        DST_AX1:  ax_next[1] = AXIS_W'(ax_clamp);
                        DST_AX2:  ax_next[2] = AXIS_W'(ax_clamp);
                        DST_SUM:  sum_next   = SUM_W'(acc_sum);
                        DST_THR2: thr2_next  = THR2_W'(acc_sum);
                        DST_DOT:  dot_next   = D_W'(acc_sum);
                        DST_N1:   n1_next    = N_W'(acc_sum);
                        DST_N2:   n2_next    = N_W'(acc_sum);
                        DST_LHS:  lhs_next   = CMP_W'(acc_sum) << COS_SHIFT;
                        DST_CC:   cc_next    = CC_W'(acc_sum);
                        DST_CCN1: ccn1_next  = CMP_W'(acc_sum);
                        DST_RHS:  rhs_next   = CMP_W'(acc_sum);
                        default:  ;
                    endcase
                    if ((item_reg.func && step_reg == CAPTURE_LAST) || step_reg == LAST_STEP)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        step_next  = step_reg + STEP_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (item_reg.func)
                    begin
                        rax_next     = ax_reg;
                        rpos_next[0] = item_reg.pos_x;
                        rpos_next[1] = item_reg.pos_y;
                        rpos_next[2] = item_reg.pos_z;
                    end
                    else
                    begin
                        run_next = RUN_W'(run_new);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the reference pose.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            run_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rax_reg[i]  <= '0;
                rpos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            run_reg   <= run_next;
            rax_reg   <= rax_next;
            rpos_reg  <= rpos_next;
        end
    end

    // Working values.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        acc_reg  <= acc_next;
        ax_reg   <= ax_next;
        sum_reg  <= sum_next;
        thr2_reg <= thr2_next;
        dot_reg  <= dot_next;
        n1_reg   <= n1_next;
        n2_reg   <= n2_next;
        lhs_reg  <= lhs_next;
        cc_reg   <= cc_next;
        ccn1_reg <= ccn1_next;
        rhs_reg  <= rhs_next;
    end

    // While waiting, the multiplier is either still working or has just finished.
    `PCD_ASSERT_SAME(a_seq_wait_mul, clk, rst_n, state_reg == ST_WAIT, mul_stat.busy || mul_stat.done)

endmodule

>>> hw/rtl/pose_change_detector_core.sv
// Top level of the pose change detector: configuration, handshakes and result register.
// Each beat carries one pose. A capture beat computes the rotated x-axis and stores
// it with the position as the reference; a check beat compares the pose with that
// reference and updates the debounce run count. All arithmetic is done by one shared
// multiplier that consumes four multiplier bits per cycle; each product is issued, runs
// through all multiplier digits and is then accumulated. A check runs 25 products and a
// capture runs 8 products; once the result is registered the block is ready for the next
// beat. One beat is processed at a time; the result register lets the next beat be
// accepted while a result waits, and a stalled output holds the block in its last step.
// Configuration writes take effect at once and are meant for when the block is idle.
`include "pose_change_detector_core_assert.svh"

module pose_change_detector_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pcd_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic signed [pcd_pkg::POS_BITS-1:0]   pos_x,
    input  logic signed [pcd_pkg::POS_BITS-1:0]   pos_y,
    input  logic signed [pcd_pkg::POS_BITS-1:0]   pos_z,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_w,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_x,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_y,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  moving,
    output logic                                  distance_over,
    output logic                                  angle_over,
    output logic [pcd_pkg::RUN_W-1:0]             run_count
);
    import pcd_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    item_t   item;
    logic    seq_ready;
    logic    res_valid;
    logic    res_ready;
    result_t result;

    assign item = '{func, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z};

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DIST:  cfg_next.dist_mm = cfg_data[DIST_W-1:0];
                CFG_COS:   cfg_next.cos     = cfg_data[COS_W-1:0];
                CFG_LIMIT: cfg_next.limit   = cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

    pcd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid),
        .item      (item),
        .ready     (seq_ready),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .result    (result)
    );

    assign in_ready  = seq_ready;
    assign res_ready = !out_valid_reg || out_ready;

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{DIST_RESET, COS_RESET, LIMIT_RESET};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign moving        = out_reg.moving;
    assign distance_over = out_reg.distance_over;
    assign angle_over    = out_reg.angle_over;
    assign run_count     = out_reg.run_count;

    // An accepted beat keeps the block busy for at least the next cycle.
    `PCD_ASSERT_NEXT(a_top_one_beat, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

>>> tb/pcd_checker.sv
// Checker of the pose change detector: predicts every result and compares it with the block.
module pcd_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pcd_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  func,
    input  logic signed [pcd_pkg::POS_BITS-1:0]   pos_x,
    input  logic signed [pcd_pkg::POS_BITS-1:0]   pos_y,
    input  logic signed [pcd_pkg::POS_BITS-1:0]   pos_z,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_w,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_x,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_y,
    input  logic signed [pcd_pkg::QUAT_BITS-1:0]  quat_z,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic                                  moving,
    input  logic                                  distance_over,
    input  logic                                  angle_over,
    input  logic [pcd_pkg::RUN_W-1:0]             run_count,
    output int                                    errors,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pcd_pkg::*;

    localparam logic signed [63:0] AXIS_LIM = 64'sd1073741823;

    // Shadow of the configuration and of the reference pose.
    logic [DIST_W-1:0]  dist_thr;
    logic [COS_W-1:0]   cos_thr;
    logic [LIMIT_W-1:0] run_limit;
    logic signed [63:0] ref_pos [3];
    logic signed [63:0] ref_axis [3];
    int unsigned        flag_count;

    result_t verdicts [$];

    // Floor shift by the fraction bits, then clamp to the axis range.
    function automatic logic signed [63:0] scale_axis(input logic signed [63:0] v);
        logic signed [63:0] s;
        begin
            s = v >>> QUAT_FRAC_BITS;
            if (s > AXIS_LIM) s = AXIS_LIM;
            if (s < -AXIS_LIM) s = -AXIS_LIM;
            return s;
        end
    endfunction

    // Works out the result of one pose beat and updates the shadow state.
    function automatic result_t judge_pose(input item_t it);
        result_t            r;
        logic signed [63:0] p [3];
        logic signed [63:0] ax [3];
        logic signed [63:0] w, x, y, z, df, d, n1, n2;
        logic [63:0]        dsum, thr2;
        logic [191:0]       lhs, rhs;
        logic               d_over, a_over;
        begin
            p[0] = it.pos_x;
            p[1] = it.pos_y;
            p[2] = it.pos_z;
            w = it.quat_w;
            x = it.quat_x;
            y = it.quat_y;
            z = it.quat_z;
            ax[0] = scale_axis(w * w + x * x - y * y - z * z);
            ax[1] = scale_axis(2 * (x * y + w * z));
            ax[2] = scale_axis(2 * (x * z - w * y));
            r = '0;
            if (it.func) begin
                for (int i = 0; i < 3; i++) begin
                    ref_pos[i] = p[i];
                    ref_axis[i] = ax[i];
                end
                r.run_count = RUN_W'(flag_count);
                return r;
            end
            // Squared distance against the squared threshold.
            dsum = '0;
            for (int i = 0; i < 3; i++) begin
                df = p[i] - ref_pos[i];
                dsum = dsum + 64'(df * df);
            end
            thr2 = 64'(dist_thr) * 64'(dist_thr);
            d_over = dsum > thr2;
            // Cosine test with squares; a zero axis never flags.
            d = 0;
            n1 = 0;
            n2 = 0;
            for (int i = 0; i < 3; i++) begin
                d = d + ref_axis[i] * ax[i];
                n1 = n1 + ref_axis[i] * ref_axis[i];
                n2 = n2 + ax[i] * ax[i];
            end
            if (n1 == 0 || n2 == 0) begin
                a_over = 1'b0;
            end
            else if (d < 0) begin
                a_over = 1'b1;
            end
            else begin
                lhs = 192'(d) * 192'(d) * (192'(1) << 30);
                rhs = 192'(cos_thr) * 192'(cos_thr) * 192'(n1) * 192'(n2);
                a_over = lhs < rhs;
            end
            // Debounce run count, clamped above the limit.
            if (d_over || a_over) flag_count = flag_count + 1;
            else flag_count = 0;
            if (flag_count > run_limit) begin
                flag_count = run_limit + 1;
                r.moving = 1'b1;
            end
            r.distance_over = d_over;
            r.angle_over = a_over;
            r.run_count = RUN_W'(flag_count);
            return r;
        end
    endfunction

    // Watch configuration writes and both channels at every edge.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            dist_thr = DIST_RESET;
            cos_thr = COS_RESET;
            run_limit = LIMIT_RESET;
            for (int i = 0; i < 3; i++) begin
                ref_pos[i] = 0;
                ref_axis[i] = 0;
            end
            flag_count = 0;
            verdicts.delete();
            errors = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DIST:  dist_thr = cfg_data[DIST_W-1:0];
                    CFG_COS:   cos_thr = cfg_data[COS_W-1:0];
                    CFG_LIMIT: run_limit = cfg_data[LIMIT_W-1:0];
                    default:   ;
                endcase
            end
            if (out_valid && out_ready) begin
                got = '{moving, distance_over, angle_over, run_count};
                if (verdicts.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %p", $time, got);
                    errors++;
                end
                else begin
                    want = verdicts.pop_front();
                    if (got.moving !== want.moving) begin
                        $display("%0t: moving expected %0b actual %0b",
                                 $time, want.moving, got.moving);
                        errors++;
                    end
                    if (got.distance_over !== want.distance_over) begin
                        $display("%0t: distance_over expected %0b actual %0b",
                                 $time, want.distance_over, got.distance_over);
                        errors++;
                    end
                    if (got.angle_over !== want.angle_over) begin
                        $display("%0t: angle_over expected %0b actual %0b",
                                 $time, want.angle_over, got.angle_over);
                        errors++;
                    end
                    if (got.run_count !== want.run_count) begin
                        $display("%0t: run_count expected %0d actual %0d",
                                 $time, want.run_count, got.run_count);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                verdicts.insert(verdicts.size(),
                                judge_pose('{func, pos_x, pos_y, pos_z,
                                             quat_w, quat_x, quat_y, quat_z}));
            end
        end
        pending = verdicts.size();
    end

endmodule

>>> tb/tb.sv
// Top of the pose change detector testbench: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcd_pkg::*;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        func = 1'b0;
    logic signed [POS_BITS-1:0]  pos_x = '0;
    logic signed [POS_BITS-1:0]  pos_y = '0;
    logic signed [POS_BITS-1:0]  pos_z = '0;
    logic signed [QUAT_BITS-1:0] quat_w = '0;
    logic signed [QUAT_BITS-1:0] quat_x = '0;
    logic signed [QUAT_BITS-1:0] quat_y = '0;
    logic signed [QUAT_BITS-1:0] quat_z = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        moving;
    logic                        distance_over;
    logic                        angle_over;
    logic [RUN_W-1:0]            run_count;
    int                          errors;
    int                          pending;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    logic        hold_req = 1'b0;
    item_t       anchor;

    localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [QUAT_BITS-1:0] ONE = 16'sd16384;

    pose_change_detector_core dut (.*);

    pcd_checker u_checker (.*);

    always #5 clk = ~clk;

    // Receiver: random stalls plus one long hold-off that it counts itself.
    always @(posedge clk)
    begin
        static int unsigned hold_left = 0;
        static logic        hold_taken = 1'b0;
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offers one pose beat, with a random gap first, and waits for acceptance.
    task automatic send_pose(input item_t it);
        begin
            if ($urandom_range(99) < send_idle) begin
                in_valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < send_idle);
            end
            in_valid <= 1'b1;
            {func, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z} <= it;
            do @(posedge clk); while (!in_ready);
        end
    endtask

    // Waits for the block to drain, then writes all registers and the unused index.
    task automatic set_config(input logic [15:0] dist_mm, input logic [15:0] cosv,
                              input logic [15:0] lim);
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (20) @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_DIST;
            cfg_data <= dist_mm;
            @(posedge clk);
            cfg_index <= CFG_COS;
            cfg_data <= cosv;
            @(posedge clk);
            cfg_index <= CFG_LIMIT;
            cfg_data <= lim;
            @(posedge clk);
            cfg_index <= CFG_IDX_W'(3);
            cfg_data <= 16'($urandom);
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    function automatic item_t pose(input logic f, input logic signed [POS_BITS-1:0] px,
                                   input logic signed [POS_BITS-1:0] py,
                                   input logic signed [POS_BITS-1:0] pz,
                                   input logic signed [15:0] qw, input logic signed [15:0] qx,
                                   input logic signed [15:0] qy, input logic signed [15:0] qz);
        return '{f, px, py, pz, qw, qx, qy, qz};
    endfunction

    function automatic logic signed [15:0] nudge(input logic signed [15:0] v, input int span);
        return 16'(int'(v) + $signed($urandom_range(2 * span)) - span);
    endfunction

    // Random pose: mostly small moves around the last captured pose.
    function automatic item_t random_pose();
        item_t it;
        int unsigned pick;
        begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                it.func = 1'b1;
                it.pos_x = POS_BITS'($urandom);
                it.pos_y = POS_BITS'($urandom);
                it.pos_z = POS_BITS'($urandom);
                it.quat_w = 16'($signed($urandom_range(32768)) - 16384);
                it.quat_x = 16'($signed($urandom_range(32768)) - 16384);
                it.quat_y = 16'($signed($urandom_range(32768)) - 16384);
                it.quat_z = 16'($signed($urandom_range(32768)) - 16384);
                anchor = it;
            end
            else if (pick < 75) begin
                it = anchor;
                it.func = 1'b0;
                it.pos_x = anchor.pos_x + POS_BITS'($signed($urandom_range(300)) - 150);
                it.pos_y = anchor.pos_y + POS_BITS'($signed($urandom_range(300)) - 150);
                it.pos_z = anchor.pos_z + POS_BITS'($signed($urandom_range(300)) - 150);
                it.quat_w = nudge(anchor.quat_w, 700);
                it.quat_x = nudge(anchor.quat_x, 700);
                it.quat_y = nudge(anchor.quat_y, 700);
                it.quat_z = nudge(anchor.quat_z, 700);
            end
            else begin
                it = item_t'({$urandom, $urandom, $urandom, $urandom});
                it.func = (pick >= 97);
                if (it.func) anchor = it;
            end
            return it;
        end
    endfunction

    // Timeout guard.
    initial
    begin
        #25ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        anchor = pose(1'b1, '0, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: before any capture, extremes, zero and tiny axes, opposite axis.
        send_pose(pose(1'b0, '0, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, PMAX, PMAX, PMAX, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b1, PMIN, PMIN, PMIN, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, PMAX, PMAX, PMAX, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, PMIN, PMIN, PMIN, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, PMIN, PMIN, PMIN, 16'sd0, 16'sd0, 16'sd0, ONE));
        send_pose(pose(1'b0, PMIN, PMIN, PMIN, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, PMIN, PMIN, PMIN, 16'sd1, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, PMIN, PMIN, PMIN, -16'sd32768, -16'sd32768, 16'sd32767,
                       -16'sd32768));
        send_pose(pose(1'b0, PMIN, PMIN, PMIN, -ONE, -ONE, ONE, -ONE));
        send_pose(pose(1'b1, '0, '0, '0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, '0, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b1, '0, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));
        // Distance right at and just past the threshold, then a run to moving.
        send_pose(pose(1'b0, 21'sd100, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));
        for (int i = 0; i < 5; i++)
            send_pose(pose(1'b0, 21'sd101, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));
        send_pose(pose(1'b0, '0, '0, '0, 16'sd15000, 16'sd0, 16'sd0, 16'sd4000));
        send_pose(pose(1'b0, '0, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));

        // A long run under the top limit, then a lowered limit clamps it.
        set_config(16'd100, 16'd32270, 16'd15);
        for (int i = 0; i < 17; i++)
            send_pose(pose(1'b0, 21'sd500, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));
        set_config(16'd100, 16'd32270, 16'd1);
        send_pose(pose(1'b0, 21'sd500, '0, '0, ONE, 16'sd0, 16'sd0, 16'sd0));

        // Random part: three idling modes, each through three settings.
        for (int ph = 0; ph < 3; ph++) begin
            for (int k = 0; k < 3; k++) begin
                case (k)
                    0: set_config(16'h0000, 16'hF000, 16'h0000);
                    1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    default: set_config(16'($urandom_range(400)),
                                        {1'($urandom), 15'($urandom_range(32767, 31000))},
                                        16'($urandom));
                endcase
                case (ph)
                    0: begin send_idle = 18; recv_idle = 86; end
                    1: begin send_idle = 86; recv_idle = 18; end
                    default: begin send_idle = 0; recv_idle = 0; end
                endcase
                if (ph == 2 && k == 0) hold_req <= 1'b1;
                for (int n = 0; n < 150; n++)
                    send_pose(random_pose());
            end
        end
        in_valid <= 1'b0;

        // Drain and verdict.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_mul.sv
hw/rtl/pcd_seq.sv
hw/rtl/pose_change_detector_core.sv
tb/pcd_checker.sv
tb/tb.sv
